// File: design/ssdf_pkg.sv
`default_nettype none
package ssdf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 12;
	localparam int WIN_N    = 7;    // deepest kernel spans seven samples
	localparam int CNT_W    = 4;
	localparam int BURST_W  = 3;    // up to seven results per input
	localparam int ACC_W    = 33;

	localparam logic [CNT_W-1:0] CNT_SAT = 4'd8;

	// register indexes
	localparam logic REG_FILTER_MODE  = 1'b0;
	localparam logic REG_INVERSE_STEP = 1'b1;

	// filter_mode register codes
	localparam logic [1:0] FM_LIGHT = 2'd0;
	localparam logic [1:0] FM_HEAVY = 2'd1;
	localparam logic [1:0] FM_DERIV = 2'd2;

	localparam logic signed [SAMPLE_W-1:0] INV_STEP_RST = 16'sd256;

	typedef enum logic [2:0] {
		MODE_LIGHT = 3'b001,
		MODE_HEAVY = 3'b010,
		MODE_DERIV = 3'b100
	} mode_t;

	typedef logic [WIN_N-1:0][SAMPLE_W-1:0] list_t;

	typedef struct packed {
		mode_t              mode;
		logic [BURST_W-1:0] n;
		logic [WIN_N-1:0]   use_f;
		logic               end_run;
		logic               short_run;
	} ctl_t;

	// Constant division: an offset multiple of the divisor keeps the numerator
	// positive, then an exact reciprocal multiply (ceil(2^(N+l)/d)) gives floor.
	localparam int DIV_LIGHT     = 452;
	localparam int NUM_LIGHT_W   = 26;
	localparam int SH_LIGHT      = 35;
	localparam int MAG_LIGHT_W   = 27;
	localparam int NUM_OFF_LIGHT = 226 + DIV_LIGHT * 65536;
	localparam longint MAG_LIGHT = ((64'd1 << SH_LIGHT) + DIV_LIGHT - 1) / DIV_LIGHT;

	localparam int DIV_HEAVY     = 5;
	localparam int NUM_HEAVY_W   = 21;
	localparam int SH_HEAVY      = 24;
	localparam int NUM_OFF_HEAVY = 2 + DIV_HEAVY * 262144;
	localparam longint MAG_HEAVY = ((64'd1 << SH_HEAVY) + DIV_HEAVY - 1) / DIV_HEAVY;

	localparam int PROD_W = NUM_LIGHT_W + MAG_LIGHT_W;

	localparam int DERIV_BIAS = 256;
	localparam int DERIV_SH   = 9;
	localparam int DER_W      = ACC_W - DERIV_SH;

endpackage
`default_nettype wire

// File: design/sample_smoothing_derivative_filter.sv
// Streaming smoothing / derivative filter for runs of signed 16-bit samples.
// Sample channel: item_valid/item_stall with sample and last; last closes a run.
// Result channel: res_valid/res_stall with value, position, end_of_run and
// too_short; results of a run come out in position order, positions from 0.
// Config channel: cfg_valid/cfg_ready (ready is always high), cfg_index 0 is
// filter_mode, 1 is inverse_step (Q8.8). Writing filter_mode drops the run in
// progress. Write configuration only while the block is idle.
// Results pass registered stages 1, 2 and 3 and then the result buffer.
// Throughput: one sample per cycle while each sample releases at most one
// result and the result side does not stall. A sample that releases several
// results (run start, run end, or a run shorter than the mode minimum) holds
// the result buffer until they, up to 7, are out, and the sample side stalls
// once the 3-stage arithmetic pipe behind that buffer is full.
// Stall on the result side propagates back to item_stall in the same cycle.
// Reset (arst_n low) empties the pipe, restores filter_mode 0 and
// inverse_step 1.0, and starts a new run at position 0.
`default_nettype none
module sample_smoothing_derivative_filter import ssdf_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       last,
	output logic                            res_valid,
	input  wire logic                       res_stall,
	output logic signed [SAMPLE_W-1:0]      value,
	output logic [POS_W-1:0]                position,
	output logic                            end_of_run,
	output logic                            too_short,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [SAMPLE_W-1:0]        cfg_data
);

	logic                       v_s1, s1_take, v_s3, s3_take, seq_clear;
	ctl_t                       ctl_s1, ctl_s3;
	list_t                      win_s1, list_s1, list_s3;
	logic signed [SAMPLE_W-1:0] inv_step;
	logic [SAMPLE_W-1:0]        f_value;

	ssdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sample     (sample),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s1_take    (s1_take),
		.v_s1       (v_s1),
		.ctl_s1     (ctl_s1),
		.win_s1     (win_s1),
		.list_s1    (list_s1),
		.inv_step   (inv_step),
		.seq_clear  (seq_clear)
	);

	ssdf_arith u_arith (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.ctl_s1   (ctl_s1),
		.win_s1   (win_s1),
		.list_s1  (list_s1),
		.inv_step (inv_step),
		.s1_take  (s1_take),
		.s3_take  (s3_take),
		.v_s3     (v_s3),
		.ctl_s3   (ctl_s3),
		.list_s3  (list_s3),
		.f_value  (f_value)
	);

	ssdf_burst u_burst (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s3       (v_s3),
		.ctl_s3     (ctl_s3),
		.list_s3    (list_s3),
		.f_value    (f_value),
		.seq_clear  (seq_clear),
		.s3_take    (s3_take),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.value      (value),
		.position   (position),
		.end_of_run (end_of_run),
		.too_short  (too_short)
	);

endmodule
`default_nettype wire

// File: design/ssdf_front.sv
`default_nettype none
module ssdf_front import ssdf_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample,
	input  wire logic                       last,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       cfg_index,
	input  wire logic [SAMPLE_W-1:0]        cfg_data,
	input  wire logic                       s1_take,
	output logic                            v_s1,
	output ctl_t                            ctl_s1,
	output list_t                           win_s1,
	output list_t                           list_s1,
	output logic signed [SAMPLE_W-1:0]      inv_step,
	output logic                            seq_clear
);

	mode_t                       mode_q;
	logic signed [SAMPLE_W-1:0]  inv_step_q;
	list_t                       win_q;
	logic [CNT_W-1:0]            cnt_q;

	logic             mode_wr, step_wr, s1_free, accept, deriv;
	list_t            win_next, list_next;
	logic [CNT_W-1:0] cnt_inc, m;
	logic [2:0]       h, h2;
	logic             short_hit, end_hit, start_hit, has_res;
	logic [WIN_N-1:0] use_f;
	ctl_t             ctl_next;
	mode_t            mode_dec;

	assign cfg_ready = 1'b1;
	assign mode_wr   = cfg_valid && (cfg_index == REG_FILTER_MODE);
	assign step_wr   = cfg_valid && (cfg_index == REG_INVERSE_STEP);
	assign seq_clear = mode_wr;
	assign inv_step  = inv_step_q;

	assign s1_free    = !v_s1 || s1_take;
	assign item_stall = !s1_free;
	assign accept     = item_valid && s1_free;

	always_comb begin
		case (cfg_data[1:0])
			FM_HEAVY: mode_dec = MODE_HEAVY;
			FM_DERIV: mode_dec = MODE_DERIV;
			default:  mode_dec = MODE_LIGHT;
		endcase
	end

	always_comb begin
		case (mode_q)
			MODE_HEAVY: h = 3'd2;
			MODE_DERIV: h = 3'd1;
			default:    h = 3'd3;
		endcase
	end

	assign deriv    = (mode_q == MODE_DERIV);
	assign h2       = 3'({h, 1'b0});
	assign m        = CNT_W'({h, 1'b0}) + 4'd2;
	assign win_next = {win_q[WIN_N-2:0], sample};
	assign cnt_inc  = (cnt_q == CNT_SAT) ? cnt_q : cnt_q + 4'd1;

	// short run: the whole run goes out raw; start: the run is known to reach
	// the minimum, so the leading edge goes out with the first filtered value
	assign short_hit = last && (cnt_inc < m);
	assign end_hit   = last && !short_hit;
	assign start_hit = !last && ((cnt_inc + 4'd1) == m);
	assign has_res   = last || ((cnt_inc + 4'd1) >= m);

	always_comb begin
		list_next = win_next;
		use_f     = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (short_hit) begin
				if (3'(i) < cnt_inc[2:0])
					list_next[i] = win_next[3'(cnt_inc[2:0] - 3'(i) - 3'd1)];
			end else if (end_hit) begin
				if (i == 0) begin
					use_f[i] = 1'b1;
				end else if (3'(i) <= h) begin
					if (deriv) use_f[i] = 1'b1;
					else       list_next[i] = win_next[3'(h - 3'(i))];
				end
			end else if (start_hit) begin
				if (3'(i) < h) begin
					if (deriv) use_f[i] = 1'b1;
					else       list_next[i] = win_next[3'(h2 - 3'(i))];
				end else if (3'(i) == h) begin
					use_f[i] = 1'b1;
				end
			end else begin
				use_f[i] = (i == 0);
			end
		end
	end

	always_comb begin
		ctl_next.mode      = mode_q;
		ctl_next.use_f     = use_f;
		ctl_next.end_run   = last;
		ctl_next.short_run = short_hit;
		if (short_hit)
			ctl_next.n = cnt_inc[BURST_W-1:0];
		else if (end_hit || start_hit)
			ctl_next.n = h + 3'd1;
		else
			ctl_next.n = 3'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_LIGHT;
			inv_step_q <= INV_STEP_RST;
			cnt_q      <= '0;
			v_s1       <= 1'b0;
		end else begin
			if (mode_wr) begin
				mode_q <= mode_dec;
				cnt_q  <= '0;
			end else if (accept) begin
				cnt_q <= last ? '0 : cnt_inc;
			end
			if (step_wr)
				inv_step_q <= cfg_data;
			if (s1_free)
				v_s1 <= accept && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q   <= win_next;
			ctl_s1  <= ctl_next;
			win_s1  <= win_next;
			list_s1 <= list_next;
		end
	end

endmodule
`default_nettype wire

// File: design/ssdf_arith.sv
`default_nettype none
module ssdf_arith import ssdf_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       v_s1,
	input  wire ctl_t                       ctl_s1,
	input  wire list_t                      win_s1,
	input  wire list_t                      list_s1,
	input  wire logic signed [SAMPLE_W-1:0] inv_step,
	output logic                            s1_take,
	input  wire logic                       s3_take,
	output logic                            v_s3,
	output ctl_t                            ctl_s3,
	output list_t                           list_s3,
	output logic [SAMPLE_W-1:0]             f_value
);

	logic                     v_s2;
	ctl_t                     ctl_s2;
	list_t                    list_s2;
	logic signed [ACC_W-1:0]  acc_s2;
	logic [PROD_W-1:0]        prod_s3;
	logic signed [DER_W-1:0]  der_s3;

	logic s2_free, s3_free;

	logic signed [ACC_W-1:0] ext [WIN_N];
	logic signed [ACC_W-1:0] pair1, pair2, acc_light, acc_heavy, acc_next;
	logic signed [16:0]      diff;
	logic signed [ACC_W-1:0] prod_d;

	logic signed [ACC_W-1:0] num_light_full, num_heavy_full, der_sum;
	logic [NUM_LIGHT_W-1:0]  mul_a;
	logic [MAG_LIGHT_W-1:0]  mul_b;
	logic                    light_s2;

	assign s3_free = !v_s3 || s3_take;
	assign s2_free = !v_s2 || s3_free;
	assign s1_take = s2_free;

	// stage 2: kernel sums, or the scaled central difference
	always_comb begin
		for (int i = 0; i < WIN_N; i++)
			ext[i] = ACC_W'($signed(win_s1[i]));
		pair1     = ext[1] + ext[5];
		pair2     = ext[2] + ext[4];
		acc_light = ext[0] + ext[6] + (pair1 <<< 4) + (pair2 <<< 6) + (pair2 <<< 4)
		            + pair2 + (ext[3] <<< 8);
		acc_heavy = ext[0] + ext[1] + ext[2] + ext[3] + ext[4];
		diff      = 17'($signed(win_s1[0])) - 17'($signed(win_s1[2]));
		prod_d    = diff * inv_step;
		case (ctl_s1.mode)
			MODE_HEAVY: acc_next = acc_heavy;
			MODE_DERIV: acc_next = prod_d;
			default:    acc_next = acc_light;
		endcase
	end

	// stage 3: reciprocal multiply shared by both smoothing modes
	assign light_s2       = (ctl_s2.mode == MODE_LIGHT);
	assign num_light_full = acc_s2 + ACC_W'(NUM_OFF_LIGHT);
	assign num_heavy_full = acc_s2 + ACC_W'(NUM_OFF_HEAVY);
	assign mul_a = light_s2 ? num_light_full[NUM_LIGHT_W-1:0]
	                        : NUM_LIGHT_W'(num_heavy_full[NUM_HEAVY_W-1:0]);
	assign mul_b = light_s2 ? MAG_LIGHT_W'(MAG_LIGHT) : MAG_LIGHT_W'(MAG_HEAVY);
	assign der_sum = acc_s2 + ACC_W'(DERIV_BIAS);

	// quotient offsets are multiples of 2^16, so the low bits are the result
	always_comb begin
		case (ctl_s3.mode)
			MODE_HEAVY: f_value = prod_s3[SH_HEAVY +: SAMPLE_W];
			MODE_DERIV: begin
				if (!der_s3[DER_W-1] && (|der_s3[DER_W-2:SAMPLE_W-1]))
					f_value = 16'h7FFF;
				else if (der_s3[DER_W-1] && !(&der_s3[DER_W-2:SAMPLE_W-1]))
					f_value = 16'h8000;
				else
					f_value = der_s3[SAMPLE_W-1:0];
			end
			default:    f_value = prod_s3[SH_LIGHT +: SAMPLE_W];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s2_free) v_s2 <= v_s1;
			if (s3_free) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			ctl_s2  <= ctl_s1;
			list_s2 <= list_s1;
			acc_s2  <= acc_next;
		end
		if (s3_free) begin
			ctl_s3  <= ctl_s2;
			list_s3 <= list_s2;
			prod_s3 <= PROD_W'(mul_a) * PROD_W'(mul_b);
			der_s3  <= DER_W'(der_sum >>> DERIV_SH);
		end
	end

endmodule
`default_nettype wire

// File: design/ssdf_burst.sv
`default_nettype none
module ssdf_burst import ssdf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  v_s3,
	input  wire ctl_t                  ctl_s3,
	input  wire list_t                 list_s3,
	input  wire logic [SAMPLE_W-1:0]   f_value,
	input  wire logic                  seq_clear,
	output logic                       s3_take,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic signed [SAMPLE_W-1:0] value,
	output logic [POS_W-1:0]           position,
	output logic                       end_of_run,
	output logic                       too_short
);

	list_t              vals_q;
	logic [BURST_W-1:0] rem_q;
	logic               v_q, end_q, short_q;
	logic [POS_W-1:0]   pos_q;

	logic  take, burst_free;
	list_t vals_next;

	assign take       = v_q && !res_stall;
	assign burst_free = !v_q || (take && (rem_q == 3'd1));
	assign s3_take    = burst_free;

	always_comb begin
		for (int i = 0; i < WIN_N; i++)
			vals_next[i] = ctl_s3.use_f[i] ? f_value : list_s3[i];
	end

	assign res_valid  = v_q;
	assign value      = vals_q[0];
	assign position   = pos_q;
	assign end_of_run = end_q && (rem_q == 3'd1);
	assign too_short  = short_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q   <= 1'b0;
			rem_q <= '0;
			pos_q <= '0;
		end else begin
			if (burst_free)
				v_q <= v_s3;
			if (burst_free && v_s3)
				rem_q <= ctl_s3.n;
			else if (take)
				rem_q <= rem_q - 3'd1;
			if (seq_clear)
				pos_q <= '0;
			else if (take)
				pos_q <= end_of_run ? '0 : pos_q + 12'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (burst_free && v_s3) begin
			vals_q  <= vals_next;
			end_q   <= ctl_s3.end_run;
			short_q <= ctl_s3.short_run;
		end else if (take) begin
			vals_q <= vals_q >> SAMPLE_W;
		end
	end

endmodule
`default_nettype wire

// File: design/ssdf_checker.sv
`default_nettype none
module ssdf_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic signed [15:0] value,
	input wire logic [11:0]        position,
	input wire logic               end_of_run,
	input wire logic               too_short
);

	logic res_take;
	assign res_take = res_valid && !res_stall;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(value) && $stable(position)
		&& $stable(end_of_run) && $stable(too_short))
		else $error("stalled result changed");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && !end_of_run |=> position == $past(position) + 12'd1)
		else $error("position did not advance by one");

	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && end_of_run |=> position == 12'd0)
		else $error("position did not restart after end of run");

	a_short_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && too_short && !end_of_run |=> res_valid && too_short)
		else $error("short run burst broken");

endmodule

bind sample_smoothing_derivative_filter ssdf_checker u_checker (.*);
`default_nettype wire
